/* rtl/software_timer_pool_defines.svh */
// Assertion macros for the software timer pool.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef SOFTWARE_TIMER_POOL_DEFINES_SVH
`define SOFTWARE_TIMER_POOL_DEFINES_SVH

// Clocked check, idle while reset is asserted.
`define STP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define STP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/stp_pkg.sv */
// Shared types and constants for the software timer pool.
// No dependencies; used by stp_ctrl, stp_dp and software_timer_pool.
`timescale 1ns / 1ps
`default_nettype none

package stp_pkg;

  localparam int          NUM_TIMERS_DEF = 8;
  localparam logic [15:0] MAX_TICKS_RST  = 16'd30000;

  typedef enum logic [2:0] {
    FUNC_TICK    = 3'd0,
    FUNC_ALLOC   = 3'd1,
    FUNC_RESTART = 3'd2,
    FUNC_READ    = 3'd3,
    FUNC_RELEASE = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_REB_RD,
    ST_REB_WR,
    ST_RESP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;      // latch request fields
    logic tick_inc;     // count <= count + 1
    logic clr_count;    // count <= 0
    logic idx_clr;
    logic idx_inc;
    logic addr_idx;     // mark store address: 1 walk index, 0 request handle
    logic wr_en;        // write mark store
    logic wr_rebase;    // write data: 1 rebased mark, 0 current count
    logic alloc_set;    // claim timer at walk index
    logic alloc_fail;
    logic release_h;    // free timer at request handle
    logic load_result;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    func_e func;
    logic  handle_ok;
    logic  tick_wrap;
    logic  busy_at_idx;
    logic  idx_last;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/stp_ctrl.sv */
// Sequencing controller for the software timer pool.
// Depends on stp_pkg; drives the command struct of stp_dp.
`timescale 1ns / 1ps
`default_nettype none

module stp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire stp_pkg::sts_t sts_i,
  output stp_pkg::cmd_t      cmd_o
);

  stp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      stp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = stp_pkg::ST_DISPATCH;
        end
      end
      stp_pkg::ST_DISPATCH: begin
        case (sts_i.func)
          stp_pkg::FUNC_TICK: begin
            cmd_o.tick_inc = 1'b1;
            if (sts_i.tick_wrap) begin
              cmd_o.idx_clr = 1'b1;
              state_d       = stp_pkg::ST_REB_RD;
            end else begin
              state_d = stp_pkg::ST_IDLE;
            end
          end
          stp_pkg::FUNC_ALLOC: begin
            cmd_o.idx_clr = 1'b1;
            state_d       = stp_pkg::ST_SCAN;
          end
          stp_pkg::FUNC_RESTART: begin
            cmd_o.wr_en = sts_i.handle_ok;
            state_d     = stp_pkg::ST_RESP;
          end
          stp_pkg::FUNC_READ: begin
            // mark is fetched at the handle this cycle
            state_d = stp_pkg::ST_RESP;
          end
          stp_pkg::FUNC_RELEASE: begin
            cmd_o.release_h = 1'b1;
            state_d         = stp_pkg::ST_RESP;
          end
          default: begin
            state_d = stp_pkg::ST_IDLE;
          end
        endcase
      end
      stp_pkg::ST_SCAN: begin
        if (!sts_i.busy_at_idx) begin
          cmd_o.alloc_set = 1'b1;
          state_d         = stp_pkg::ST_RESP;
        end else if (sts_i.idx_last) begin
          cmd_o.alloc_fail = 1'b1;
          state_d          = stp_pkg::ST_RESP;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      stp_pkg::ST_REB_RD: begin
        cmd_o.addr_idx = 1'b1;
        state_d        = stp_pkg::ST_REB_WR;
      end
      stp_pkg::ST_REB_WR: begin
        cmd_o.addr_idx  = 1'b1;
        cmd_o.wr_rebase = 1'b1;
        cmd_o.wr_en     = sts_i.busy_at_idx;
        if (sts_i.idx_last) begin
          cmd_o.clr_count = 1'b1;
          state_d         = stp_pkg::ST_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = stp_pkg::ST_REB_RD;
        end
      end
      stp_pkg::ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = stp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = stp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/stp_dp.sv */
// Datapath of the software timer pool: tick count, busy flags, start mark
// store, walk index and result register. Depends on stp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stp_dp #(
  parameter int NUM_TIMERS = stp_pkg::NUM_TIMERS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [15:0]   cfg_wdata_i,
  input  wire logic [2:0]    func_i,
  input  wire logic [2:0]    handle_i,
  input  wire stp_pkg::cmd_t cmd_i,
  output stp_pkg::sts_t      sts_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic               status_o,
  output logic [2:0]         handle_out_o,
  output logic [15:0]        elapsed_o
);

  localparam int IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic [15:0]           max_q;
  logic [15:0]           count_q;
  logic [15:0]           count_inc;
  logic [NUM_TIMERS-1:0] busy_q;
  logic [IdxW-1:0]       idx_q;
  logic [2:0]            func_q;
  logic [2:0]            handle_q;
  logic                  fail_q;
  logic                  handle_ok;
  logic [IdxW-1:0]       handle_addr;
  logic [IdxW-1:0]       addr;
  logic [15:0]           wr_data;
  logic [15:0]           rd_q;
  logic [15:0]           mark_mem [NUM_TIMERS];
  logic                  out_valid_q;
  logic                  status_q;
  logic [2:0]            handle_out_q;
  logic [15:0]           elapsed_q;

  assign count_inc   = count_q + 16'd1;
  assign handle_ok   = 32'(handle_q) < NUM_TIMERS;
  assign handle_addr = IdxW'(handle_q);
  assign addr        = cmd_i.addr_idx ? idx_q : handle_addr;
  assign wr_data     = cmd_i.wr_rebase ? (rd_q - count_q) : count_q;

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= stp_pkg::MAX_TICKS_RST;
      count_q     <= '0;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_count) begin
        count_q <= '0;
      end else if (cmd_i.tick_inc) begin
        count_q <= count_inc;
      end
      if (cmd_i.alloc_set) begin
        busy_q[idx_q] <= 1'b1;
      end else if (cmd_i.release_h && handle_ok) begin
        busy_q[handle_addr] <= 1'b0;
      end
      if (cmd_i.load_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request fields and walk index
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= func_i;
      handle_q <= handle_i;
      fail_q   <= 1'b0;
    end else if (cmd_i.alloc_set) begin
      handle_q <= 3'(idx_q);
    end else if (cmd_i.alloc_fail) begin
      fail_q <= 1'b1;
    end
    if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // start mark store, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mark_mem[addr] <= wr_data;
    end
    rd_q <= mark_mem[addr];
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      status_q     <= fail_q;
      handle_out_q <= handle_q;
      if ((stp_pkg::func_e'(func_q) == stp_pkg::FUNC_READ) && handle_ok) begin
        elapsed_q <= count_q - rd_q;
      end else begin
        elapsed_q <= '0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign handle_out_o      = handle_out_q;
  assign elapsed_o         = elapsed_q;
  assign sts_o.func        = stp_pkg::func_e'(func_q);
  assign sts_o.handle_ok   = handle_ok;
  assign sts_o.tick_wrap   = count_inc >= max_q;
  assign sts_o.busy_at_idx = busy_q[idx_q];
  assign sts_o.idx_last    = idx_q == IdxW'(NUM_TIMERS - 1);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

/* rtl/software_timer_pool.sv */
// Software timer pool top level: controller plus datapath.
// Depends on stp_pkg, stp_ctrl, stp_dp and software_timer_pool_defines.svh.
//
// Usage:
//  - Request channel (in_valid_i/in_ready_o) carries func_i and handle_i.
//    One transaction is taken at a time; in_ready_o is high only while the
//    controller is idle.
//  - Result channel (out_valid_o/out_ready_i) carries status_o, handle_out_o
//    and elapsed_o. Tick and unknown requests give no result.
//  - User rule: write max_ticks via cfg_we_i/cfg_wdata_i only while idle; not enforced.
// Controller states from one accept to the next accept:
//  - tick: IDLE, DISPATCH; when the count reaches max_ticks, REB_RD and REB_WR
//    per timer (a read and, if busy, a write of the single-port start mark store).
//  - allocate: IDLE, DISPATCH, SCAN (at most NUM_TIMERS timers checked), RESP;
//    the free-timer search checks one busy flag per cycle.
//  - restart, read, release: IDLE, DISPATCH, RESP; result valid once RESP loads it.
// Stall: a held result sits in the output register while the next request
// is accepted; a new result waits in the controller until the held one is taken.
// Reset: count 0, max_ticks 30000, every timer free, no result pending.
// Start marks are not cleared; read a timer only after a restart.
`timescale 1ns / 1ps
`default_nettype none
`include "software_timer_pool_defines.svh"

module software_timer_pool #(
  parameter int NUM_TIMERS = stp_pkg::NUM_TIMERS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  func_i,
  input  wire logic [2:0]  handle_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             status_o,
  output logic [2:0]       handle_out_o,
  output logic [15:0]      elapsed_o
);

  stp_pkg::cmd_t cmd;
  stp_pkg::sts_t sts;

  stp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stp_dp #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .func_i       (func_i),
    .handle_i     (handle_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .handle_out_o (handle_out_o),
    .elapsed_o    (elapsed_o)
  );

  // one request in flight: no accept right after an accept
  `STP_ASSERT(a_one_in_flight, (in_valid_i && in_ready_o) |=> !in_ready_o, "second accept")
  // a new result never overwrites one not yet taken
  `STP_ASSERT(a_no_overwrite, cmd.load_result |-> (!out_valid_o || out_ready_i), "result lost")
  // a restart write only lands on an existing timer
  `STP_ASSERT(a_wr_in_range, (cmd.wr_en && !cmd.addr_idx) |-> sts.handle_ok, "bad mark write")
  // a full pool reports no elapsed time
  `STP_ASSERT(a_fail_no_elapsed, (out_valid_o && status_o) |-> (elapsed_o == 16'd0), "bad fail")
  // no result is loaded while reset holds the controller idle
  `STP_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !cmd.load_result, "load in reset")

endmodule

`default_nettype wire
